// ----- rtl/frqs_pkg.sv -----
// frqs_pkg: shared types and constants for the fifo ready queue scheduler
// used by rtl/fifo_ready_queue_scheduler.sv and rtl/frqs_chk.sv
// no dependencies
package frqs_pkg;

    localparam int NUM_PROCS = 32;
    localparam int NUM_HARTS = 4;
    localparam int PID_W     = 5;
    localparam int HART_W    = 2;
    localparam int ST_W      = 3;
    localparam int OUT_W     = 3;
    localparam int CNT_W     = $clog2(NUM_PROCS + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SCHED  = 2'd1,
        OP_SET    = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_FREE    = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_ZOMBIE  = 3'd4
    } t_status;

    typedef enum logic [OUT_W-1:0] {
        OUT_INSERTED   = 3'd0,
        OUT_ALREADY    = 3'd1,
        OUT_DISPATCHED = 3'd2,
        OUT_SHUTDOWN   = 3'd3,
        OUT_HOLD       = 3'd4,
        OUT_STUCK      = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2
    } t_state;

endpackage

// ----- rtl/fifo_ready_queue_scheduler.sv -----
// fifo_ready_queue_scheduler: fifo ready queue of process ids with a status table
// depends on frqs_pkg
//
// usage: a command is taken on a rising edge with start high and busy low;
// i_operation selects insert, schedule or set status, with i_proc_id,
// i_new_status and i_hart_id as operands. each command gives one result,
// shown on o_outcome and o_chosen_proc for exactly one cycle with o_strobe
// high; the receiver has no way to stall it.
// insert, set status and a schedule on an empty queue read the status
// memory and give their result from state S_RD1; a dispatching schedule
// also passes through S_RD2, since the queue slot memory is read first and
// its output then addresses the status memory. both memories have a
// registered read. busy is high from the cycle after accept until the
// result appears; a new command is taken in the cycle the result is shown,
// so a command is not taken before the last one is through.
// reset: synchronous, active low. it empties the queue, clears the in-queue
// bits and the status valid bits (every process reads as free) and zeroes
// the live counter. the slot memory needs no clearing pass.
module fifo_ready_queue_scheduler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [frqs_pkg::PID_W-1:0]  i_proc_id,
    input  logic [frqs_pkg::ST_W-1:0]   i_new_status,
    input  logic [frqs_pkg::HART_W-1:0] i_hart_id,
    output logic                      o_strobe,
    output logic [frqs_pkg::OUT_W-1:0]  o_outcome,
    output logic [frqs_pkg::PID_W-1:0]  o_chosen_proc
);
    import frqs_pkg::*;

    localparam logic [PID_W:0]   NPROC_L = (PID_W+1)'(NUM_PROCS);
    localparam logic [PID_W-1:0] LAST_SLOT = PID_W'(NUM_PROCS - 1);

    // memories
    logic [PID_W-1:0] mem_slot [NUM_PROCS];
    logic [ST_W-1:0]  mem_st   [NUM_PROCS];

    t_state r_state, n_state;
    logic [1:0]        r_op;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [ST_W-1:0]   r_nst;
    logic [HART_W-1:0] r_hart;

    logic [PID_W-1:0]  r_slot_rd;
    logic [ST_W-1:0]   r_st_rd;
    logic              r_st_rd_vld;

    logic [PID_W-1:0]     r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]     r_qcnt, n_qcnt, r_live, n_live;
    logic [NUM_PROCS-1:0] r_inq, n_inq, r_st_vld, n_st_vld;

    logic             r_strobe, n_strobe;
    logic [OUT_W-1:0] r_outcome, n_outcome;
    logic [PID_W-1:0] r_chosen, n_chosen;

    logic             accept;
    logic [PID_W-1:0] st_raddr;
    logic             st_re;
    logic             st_we, slot_we;
    logic [ST_W-1:0]  st_wdata;
    logic [ST_W-1:0]  old_st;
    logic             old_live, new_live;
    logic             pid_ok;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign o_strobe      = r_strobe;
    assign o_outcome     = r_outcome;
    assign o_chosen_proc = r_chosen;

    // status read: command operand when idle, dequeued id for a dispatch
    assign st_raddr = (r_state == S_IDLE) ? i_proc_id : r_slot_rd;
    assign st_re    = (r_state == S_IDLE) || (r_state == S_RD1);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_slot_rd <= mem_slot[r_head];
        end
        if (st_re) begin
            r_st_rd     <= mem_st[st_raddr];
            r_st_rd_vld <= r_st_vld[st_raddr];
        end
        if (slot_we) begin
            mem_slot[r_tail] <= r_pid;
        end
        if (st_we) begin
            mem_st[r_pid] <= st_wdata;
        end
        if (accept) begin
            r_op   <= i_operation;
            r_nst  <= i_new_status;
            r_hart <= i_hart_id;
        end
        r_pid     <= n_pid;
        r_outcome <= n_outcome;
        r_chosen  <= n_chosen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_qcnt   <= '0;
            r_live   <= '0;
            r_inq    <= '0;
            r_st_vld <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_qcnt   <= n_qcnt;
            r_live   <= n_live;
            r_inq    <= n_inq;
            r_st_vld <= n_st_vld;
            r_strobe <= n_strobe;
        end
    end

    // an entry never written reads as free
    assign old_st   = r_st_rd_vld ? r_st_rd : ST_FREE;
    assign old_live = (old_st != ST_FREE) && (old_st != ST_ZOMBIE);
    assign new_live = (st_wdata != ST_FREE) && (st_wdata != ST_ZOMBIE);
    assign pid_ok   = ({1'b0, r_pid} < NPROC_L);

    always_comb begin
        n_state   = r_state;
        n_pid     = r_pid;
        n_head    = r_head;
        n_tail    = r_tail;
        n_qcnt    = r_qcnt;
        n_live    = r_live;
        n_inq     = r_inq;
        n_st_vld  = r_st_vld;
        n_strobe  = 1'b0;
        n_outcome = r_outcome;
        n_chosen  = r_chosen;
        st_we     = 1'b0;
        slot_we   = 1'b0;
        st_wdata  = ST_FREE;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pid   = i_proc_id;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_outcome = OUT_INSERTED;
                n_chosen  = '0;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
                unique case (r_op)
                    OP_INSERT: begin
                        if (!pid_ok || r_inq[r_pid]) begin
                            n_outcome = OUT_ALREADY;
                        end else begin
                            slot_we       = 1'b1;
                            n_tail        = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                            n_qcnt        = r_qcnt + 1'b1;
                            n_inq[r_pid]  = 1'b1;
                            st_we         = 1'b1;
                            st_wdata      = ST_READY;
                        end
                    end
                    OP_SCHED: begin
                        if (r_qcnt != '0) begin
                            // status of the head process arrives next cycle
                            n_pid    = r_slot_rd;
                            n_strobe = 1'b0;
                            n_state  = S_RD2;
                        end else if (r_live == '0) begin
                            n_outcome = (r_hart == '0) ? OUT_SHUTDOWN : OUT_HOLD;
                        end else begin
                            n_outcome = OUT_STUCK;
                        end
                    end
                    OP_SET: begin
                        if (pid_ok && (r_nst <= ST_ZOMBIE)) begin
                            st_we    = 1'b1;
                            st_wdata = r_nst;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD2: begin
                n_head        = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                n_qcnt        = r_qcnt - 1'b1;
                n_inq[r_pid]  = 1'b0;
                st_we         = 1'b1;
                st_wdata      = ST_RUNNING;
                n_outcome     = OUT_DISPATCHED;
                n_chosen      = r_pid;
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (st_we) begin
            n_st_vld[r_pid] = 1'b1;
            if (old_live && !new_live && (r_live != '0)) begin
                n_live = r_live - 1'b1;
            end else if (!old_live && new_live) begin
                n_live = r_live + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/frqs_chk.sv -----
// frqs_chk: port-level assertions for the fifo ready queue scheduler
// depends on frqs_pkg; bound to fifo_ready_queue_scheduler below
module frqs_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [frqs_pkg::OUT_W-1:0]  o_outcome,
    input logic [frqs_pkg::PID_W-1:0]  o_chosen_proc
);
    import frqs_pkg::*;

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result is shown only once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe while busy");

    // busy always ends in exactly one result
    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // chosen id only on dispatch
    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_outcome != OUT_DISPATCHED) |-> (o_chosen_proc == '0))
        else $error("chosen id set without dispatch");

    a_outcome_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_outcome <= OUT_STUCK))
        else $error("outcome code out of range");

endmodule

bind fifo_ready_queue_scheduler frqs_chk u_frqs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_outcome     (o_outcome),
    .o_chosen_proc (o_chosen_proc)
);

// ----- verif/frqs_outcome_checker.sv -----
// frqs_outcome_checker: watches the command and result ports of the ready queue scheduler,
// predicts each outcome and compares it with what the block returns
// depends on frqs_pkg
module frqs_outcome_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_operation,
    input  logic [frqs_pkg::PID_W-1:0]  i_proc_id,
    input  logic [frqs_pkg::ST_W-1:0]   i_new_status,
    input  logic [frqs_pkg::HART_W-1:0] i_hart_id,
    input  logic                        i_strobe,
    input  logic [frqs_pkg::OUT_W-1:0]  i_outcome,
    input  logic [frqs_pkg::PID_W-1:0]  i_chosen_proc,
    output int                          o_fail_count,
    output int                          o_pending
);
    import frqs_pkg::*;

    typedef struct packed {
        t_outcome          outcome;
        logic [PID_W-1:0]  proc_id;
    } t_sched_result;

    // shadow copy of the scheduler tables
    logic [PID_W-1:0] ready_slots [NUM_PROCS];
    logic [PID_W-1:0] head_idx;
    logic [PID_W-1:0] tail_idx;
    logic [CNT_W-1:0] queued_total;
    logic [CNT_W-1:0] live_total;
    logic             queued_flag [NUM_PROCS];
    t_status          proc_state [NUM_PROCS];

    t_sched_result    expected_outcomes [$];
    int               mismatch_total = 0;

    function automatic logic is_live(t_status s);
        return s != ST_FREE && s != ST_ZOMBIE;
    endfunction

    function automatic logic [PID_W-1:0] wrap_next(logic [PID_W-1:0] idx);
        return (int'(idx) == NUM_PROCS - 1) ? '0 : idx + 1'b1;
    endfunction

    task automatic clear_tables();
        head_idx     = '0;
        tail_idx     = '0;
        queued_total = '0;
        live_total   = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            ready_slots[p] = '0;
            queued_flag[p] = 1'b0;
            proc_state[p]  = ST_FREE;
        end
    endtask

    task automatic change_status(input logic [PID_W-1:0] pid, input t_status s);
        logic was_live;
        logic now_live;
        was_live = is_live(proc_state[pid]);
        now_live = is_live(s);
        if (was_live && !now_live && live_total != 0)
            live_total = live_total - 1'b1;
        else if (!was_live && now_live)
            live_total = live_total + 1'b1;
        proc_state[pid] = s;
    endtask

    task automatic schedule_step(
        input  logic [1:0]        op,
        input  logic [PID_W-1:0]  pid,
        input  logic [ST_W-1:0]   st,
        input  logic [HART_W-1:0] hart,
        output t_sched_result     res
    );
        logic [PID_W-1:0] head_pid;
        res.outcome = OUT_INSERTED;
        res.proc_id = '0;
        case (op)
            OP_INSERT: begin
                if (int'(pid) >= NUM_PROCS || queued_flag[pid]) begin
                    res.outcome = OUT_ALREADY;
                end else begin
                    ready_slots[tail_idx] = pid;
                    tail_idx              = wrap_next(tail_idx);
                    queued_total          = queued_total + 1'b1;
                    queued_flag[pid]      = 1'b1;
                    change_status(pid, ST_READY);
                end
            end
            OP_SCHED: begin
                if (queued_total != 0) begin
                    // head goes out whatever its status
                    head_pid              = ready_slots[head_idx];
                    head_idx              = wrap_next(head_idx);
                    queued_total          = queued_total - 1'b1;
                    queued_flag[head_pid] = 1'b0;
                    change_status(head_pid, ST_RUNNING);
                    res.outcome = OUT_DISPATCHED;
                    res.proc_id = head_pid;
                end else if (live_total == 0) begin
                    res.outcome = (hart == '0) ? OUT_SHUTDOWN : OUT_HOLD;
                end else begin
                    res.outcome = OUT_STUCK;
                end
            end
            OP_SET: begin
                if (int'(pid) < NUM_PROCS && st <= ST_ZOMBIE)
                    change_status(pid, t_status'(st));
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_sched_result want;
        t_sched_result predicted;
        if (!i_rst_n) begin
            clear_tables();
            expected_outcomes.delete();
        end else begin
            // the result leaving and a new transaction can share one edge
            if (i_strobe) begin
                if (expected_outcomes.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result with none expected, outcome %0d proc %0d",
                             $time, i_outcome, i_chosen_proc);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_outcome !== want.outcome) begin
                        mismatch_total++;
                        $display("%0t: outcome expected %0d actual %0d",
                                 $time, want.outcome, i_outcome);
                    end
                    if (i_chosen_proc !== want.proc_id) begin
                        mismatch_total++;
                        $display("%0t: chosen_proc expected %0d actual %0d",
                                 $time, want.proc_id, i_chosen_proc);
                    end
                end
            end
            if (i_start && !i_busy) begin
                schedule_step(i_operation, i_proc_id, i_new_status, i_hart_id, predicted);
                expected_outcomes.push_back(predicted);
            end
        end
        o_pending    <= expected_outcomes.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ----- verif/testbench.sv -----
// testbench: drives commands into the fifo ready queue scheduler and gives the verdict
// depends on frqs_pkg, rtl/fifo_ready_queue_scheduler.sv and verif/frqs_outcome_checker.sv
module testbench;
    import frqs_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 170;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic [1:0]        i_operation  = '0;
    logic [PID_W-1:0]  i_proc_id    = '0;
    logic [ST_W-1:0]   i_new_status = '0;
    logic [HART_W-1:0] i_hart_id    = '0;
    logic              busy;
    logic              o_strobe;
    logic [OUT_W-1:0]  o_outcome;
    logic [PID_W-1:0]  o_chosen_proc;

    int fail_count;
    int pending_count;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    int idle_plan [4]   = '{0, 84, 0, 26};

    always #1 i_clk = ~i_clk;

    fifo_ready_queue_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_proc_id     (i_proc_id),
        .i_new_status  (i_new_status),
        .i_hart_id     (i_hart_id),
        .o_strobe      (o_strobe),
        .o_outcome     (o_outcome),
        .o_chosen_proc (o_chosen_proc)
    );

    frqs_outcome_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_proc_id     (i_proc_id),
        .i_new_status  (i_new_status),
        .i_hart_id     (i_hart_id),
        .i_strobe      (o_strobe),
        .i_outcome     (o_outcome),
        .i_chosen_proc (o_chosen_proc),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // one transaction; start stays high when the next one follows without a gap
    task automatic issue(
        input logic [1:0]        op,
        input logic [PID_W-1:0]  pid,
        input logic [ST_W-1:0]   st,
        input logic [HART_W-1:0] hart
    );
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_proc_id    <= pid;
        i_new_status <= st;
        i_hart_id    <= hart;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [PID_W-1:0] any_pid();
        return PID_W'($urandom_range(0, NUM_PROCS - 1));
    endfunction

    function automatic logic [HART_W-1:0] any_hart();
        return HART_W'($urandom_range(0, (1 << HART_W) - 1));
    endfunction

    function automatic logic [ST_W-1:0] any_status();
        // mostly legal codes, some out of range
        if ($urandom_range(0, 9) < 8)
            return ST_W'($urandom_range(0, ST_ZOMBIE));
        return ST_W'($urandom_range(ST_ZOMBIE + 1, (1 << ST_W) - 1));
    endfunction

    task automatic random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            issue(OP_INSERT, any_pid(), any_status(), any_hart());
        else if (pick < 75)
            issue(OP_SCHED, any_pid(), any_status(), any_hart());
        else if (pick < 95)
            issue(OP_SET, any_pid(), any_status(), any_hart());
        else
            issue(OP_UNUSED, any_pid(), any_status(), any_hart());
    endtask

    // empty the queue, retire every process, then probe the empty queue
    task automatic drain_and_retire();
        repeat (NUM_PROCS + 2) issue(OP_SCHED, any_pid(), any_status(), any_hart());
        for (int p = 0; p < NUM_PROCS; p++)
            issue(OP_SET, PID_W'(p), $urandom_range(0, 1) ? ST_FREE : ST_ZOMBIE, any_hart());
        repeat (3) issue(OP_SCHED, any_pid(), any_status(), any_hart());
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue with nothing live, for harts 0, 1 and 3
        issue(OP_SCHED, '0, '0, 2'd0);
        issue(OP_SCHED, '0, '0, 2'd1);
        issue(OP_SCHED, '1, '1, 2'd3);
        issue(OP_INSERT, '0, '0, '0);
        issue(OP_INSERT, '1, '1, '1);
        issue(OP_INSERT, '0, ST_READY, '0);
        issue(OP_SET, '1, ST_BLOCKED, '0);
        issue(OP_SET, 5'd5, '1, '0);
        issue(OP_UNUSED, '1, '1, '1);
        issue(OP_SCHED, '0, '0, 2'd2);
        issue(OP_SCHED, '0, '0, 2'd1);
        // empty queue while processes are still live
        issue(OP_SCHED, '0, '0, 2'd0);
        issue(OP_SET, '0, ST_ZOMBIE, '0);
        issue(OP_SET, '1, ST_FREE, '0);
        issue(OP_SCHED, '0, '0, 2'd0);
        issue(OP_SET, 5'd5, ST_READY, '0);
        issue(OP_SCHED, '0, '0, 2'd2);
        issue(OP_SET, 5'd5, ST_FREE, '0);
        // queued process freed before its dispatch
        issue(OP_INSERT, 5'd7, '0, '0);
        issue(OP_SET, 5'd7, ST_FREE, '0);
        issue(OP_SCHED, '0, '0, 2'd1);
        issue(OP_SET, 5'd7, ST_FREE, '0);
        issue(OP_SCHED, '0, '0, 2'd0);
        wait_all_results();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_plan[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_command();
            drain_and_retire();
            wait_all_results();
            repeat (4) @(posedge i_clk);
        end

        sender_idle_pct = 0;
        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
